[hdl/gesolv_pkg.sv]
package gesolv_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [NODE_W-1:0]    node;
    logic [MAX_NODES-1:0] attackers;
    logic                 in_graph;
    logic                 in_candidate;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] result_node;
    logic              in_extension;
    logic              still_undecided;
    logic              last;
  } out_item_t;

endpackage

[hdl/grounded_extension_solver.sv]
// Grounded extension solver for an argumentation framework of up to 64 nodes.
// Input channel (in_valid / in_stall / in_data): a load item writes one node's
// attacker row plus its graph and candidate flags; a compute item runs the
// fixed point and then reports one result item per node 0 .. node_count-1,
// the final one marked with last. Loads produce no result. node_count is
// written via cfg_we / cfg_data; the user must do so only while the block is
// idle; the block does not enforce it. 0 acts as 1, values above 64 as 64.
// The attacker rows live in a 64 x 64 memory read one row per cycle. Each
// round walks the rows twice: once to find the new unattacked candidates N,
// once to find the nodes that N attacks. Each pass issues reads of rows 0 ..
// n-1 and tests each row as its registered read returns. After r productive
// rounds and a last pass that finds no new N, the results follow, one result
// per cycle while the receiver keeps out_stall low. r is at most n.
// in_stall is high while a compute item is in flight or results are being
// issued; the next item is taken as soon as the last result is in the output
// register, even if that result still waits. When the receiver stalls, the
// output register holds its item and the sequencer waits.
// Reset clears the flag sets and the node count (to 64) and empties the
// output register; attacker rows are undefined until loaded.
module grounded_extension_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gesolv_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gesolv_pkg::in_item_t        in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gesolv_pkg::out_item_t       out_data
);
  import gesolv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN_N, S_SCAN_HIT, S_EMIT} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   node_count;
  logic [COUNT_W-1:0]   n_act;
  logic [MAX_NODES-1:0] graph_flags;
  logic [MAX_NODES-1:0] candidate_flags;
  logic [MAX_NODES-1:0] cset;
  logic [MAX_NODES-1:0] iset;
  logic [MAX_NODES-1:0] eset;
  logic [MAX_NODES-1:0] nset;
  logic [MAX_NODES-1:0] hitc;
  logic [MAX_NODES-1:0] hiti;
  logic [COUNT_W-1:0]   issue_idx;
  logic                 proc_valid;
  logic [NODE_W-1:0]    proc_idx;
  logic [COUNT_W-1:0]   emit_idx;

  // attacker row memory
  logic [MAX_NODES-1:0] attack_rows [MAX_NODES];
  logic [MAX_NODES-1:0] rd_row;
  logic [NODE_W-1:0]    rd_addr;

  logic                 in_fire;
  logic                 load_fire;
  logic                 issue_more;
  logic                 proc_last;
  logic [MAX_NODES-1:0] proc_bit;
  logic                 n_hit;
  logic                 c_hit;
  logic                 i_hit;
  logic [MAX_NODES-1:0] nset_next;
  logic [MAX_NODES-1:0] hitc_next;
  logic [MAX_NODES-1:0] hiti_next;
  logic [COUNT_W-1:0]   n_clamp;
  logic [MAX_NODES-1:0] act_mask;
  logic                 out_free;
  logic [NODE_W-1:0]    emit_node;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (in_data.operation == OP_LOAD);
  assign rd_addr   = issue_idx[NODE_W-1:0];
  assign out_free  = !out_valid || !out_stall;
  assign emit_node = emit_idx[NODE_W-1:0];

  always_ff @(posedge clk) begin
    if (load_fire) begin
      attack_rows[in_data.node] <= in_data.attackers;
    end
    rd_row <= attack_rows[rd_addr];
  end

  always_comb begin
    // clamp the register to 1 .. MAX_NODES
    if (node_count == '0) begin
      n_clamp = COUNT_W'(1);
    end else if (node_count > COUNT_W'(MAX_NODES)) begin
      n_clamp = COUNT_W'(MAX_NODES);
    end else begin
      n_clamp = node_count;
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      act_mask[i] = (COUNT_W'(i) < n_clamp);
    end
  end

  always_comb begin
    issue_more = (issue_idx < n_act);
    proc_last  = proc_valid && (proc_idx == NODE_W'(n_act - COUNT_W'(1)));
    proc_bit   = MAX_NODES'(1) << proc_idx;
    n_hit      = proc_valid && cset[proc_idx] && ((rd_row & iset) == '0);
    c_hit      = proc_valid && cset[proc_idx] && (|(rd_row & nset));
    i_hit      = proc_valid && iset[proc_idx] && (|(rd_row & nset));
    nset_next  = n_hit ? (nset | proc_bit) : nset;
    hitc_next  = c_hit ? (hitc | proc_bit) : hitc;
    hiti_next  = i_hit ? (hiti | proc_bit) : hiti;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      node_count      <= COUNT_W'(MAX_NODES);
      graph_flags     <= '0;
      candidate_flags <= '0;
      eset            <= '0;
      iset            <= '0;
      proc_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end

      // drain the output register when the receiver takes the item
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (load_fire) begin
            graph_flags[in_data.node]     <= in_data.in_graph;
            candidate_flags[in_data.node] <= in_data.in_candidate;
          end else if (in_fire) begin
            n_act      <= n_clamp;
            cset       <= candidate_flags & act_mask;
            iset       <= graph_flags & act_mask;
            eset       <= '0;
            nset       <= '0;
            issue_idx  <= '0;
            proc_valid <= 1'b0;
            state      <= S_SCAN_N;
          end
        end

        S_SCAN_N: begin
          // issue row reads and test each candidate against I
          proc_valid <= issue_more;
          proc_idx   <= issue_idx[NODE_W-1:0];
          if (issue_more) begin
            issue_idx <= issue_idx + COUNT_W'(1);
          end
          nset <= nset_next;
          if (proc_last) begin
            issue_idx  <= '0;
            proc_valid <= 1'b0;
            hitc       <= '0;
            hiti       <= '0;
            if (nset_next == '0) begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              eset  <= eset | nset_next;
              state <= S_SCAN_HIT;
            end
          end
        end

        S_SCAN_HIT: begin
          // mark C and I nodes attacked by N
          proc_valid <= issue_more;
          proc_idx   <= issue_idx[NODE_W-1:0];
          if (issue_more) begin
            issue_idx <= issue_idx + COUNT_W'(1);
          end
          hitc <= hitc_next;
          hiti <= hiti_next;
          if (proc_last) begin
            cset       <= cset & ~(nset | hitc_next);
            iset       <= iset & ~(nset | hiti_next);
            nset       <= '0;
            issue_idx  <= '0;
            proc_valid <= 1'b0;
            state      <= S_SCAN_N;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.result_node     <= emit_node;
            out_data.in_extension    <= eset[emit_node];
            out_data.still_undecided <= iset[emit_node];
            out_data.last            <= (emit_idx == n_act - COUNT_W'(1));
            emit_idx                 <= emit_idx + COUNT_W'(1);
            if (emit_idx == n_act - COUNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/tb_grounded_extension_solver.sv]
`timescale 1ns / 1ps

module tb_grounded_extension_solver;
  import gesolv_pkg::*;

  // Timeout, several times above the slowest correct run: about 360 items,
  // each a full fixed-point walk over 64 nodes plus 64 stalled results.
  localparam int unsigned CYCLE_LIMIT  = 16_000_000;
  // Settle time after the last result before a node_count write or the end.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Track the argument graph, predict the grounded labelling for every
  // compute item, and compare the reported labels in order.
  class grounded_board;
    logic [MAX_NODES-1:0] attack_rows [MAX_NODES];
    logic [MAX_NODES-1:0] graph_set;
    logic [MAX_NODES-1:0] cand_set;
    int unsigned          active_n;
    out_item_t            pending_labels [$];
    int unsigned          mismatches;
    int unsigned          labels_seen;
    int unsigned          loads_seen;
    int unsigned          computes_seen;

    function new();
      foreach (attack_rows[k]) attack_rows[k] = '0;
      graph_set     = '0;
      cand_set      = '0;
      active_n      = MAX_NODES;
      mismatches    = 0;
      labels_seen   = 0;
      loads_seen    = 0;
      computes_seen = 0;
    endfunction

    // Clamp node_count: zero acts as one, anything past the array as full size.
    function void set_count(logic [COUNT_W-1:0] v);
      int unsigned req;
      req = 32'(v);
      if (req == 0) active_n = 1;
      else if (req > MAX_NODES) active_n = MAX_NODES;
      else active_n = req;
    endfunction

    // Iterate to the fixed point: accept unattacked candidates, then strip
    // them and everything they attack from the candidate and undecided sets.
    function void settle(output logic [MAX_NODES-1:0] eset,
                         output logic [MAX_NODES-1:0] iset);
      logic [MAX_NODES-1:0] live;
      logic [MAX_NODES-1:0] cset;
      logic [MAX_NODES-1:0] fresh;
      logic [MAX_NODES-1:0] hit_c;
      logic [MAX_NODES-1:0] hit_i;
      live = (active_n >= MAX_NODES) ? '1 : ((64'd1 << active_n) - 64'd1);
      cset = cand_set & live;
      iset = graph_set & live;
      eset = '0;
      do begin
        fresh = '0;
        hit_c = '0;
        hit_i = '0;
        for (int x = 0; x < active_n; x++)
          if (cset[x] && ((attack_rows[x] & live & iset) == '0)) fresh[x] = 1'b1;
        for (int x = 0; x < active_n; x++)
          if ((attack_rows[x] & live & fresh) != '0) begin
            hit_c[x] = cset[x];
            hit_i[x] = iset[x];
          end
        eset |= fresh;
        cset &= ~(fresh | hit_c);
        iset &= ~(fresh | hit_i);
      end while (fresh != '0);
    endfunction

    function void note_item(in_item_t it);
      logic [MAX_NODES-1:0] eset;
      logic [MAX_NODES-1:0] iset;
      out_item_t            lbl;
      if (it.operation == OP_LOAD) begin
        attack_rows[it.node] = it.attackers;
        graph_set[it.node]   = it.in_graph;
        cand_set[it.node]    = it.in_candidate;
        loads_seen++;
      end else begin
        settle(eset, iset);
        for (int k = 0; k < active_n; k++) begin
          lbl.result_node     = NODE_W'(k);
          lbl.in_extension    = eset[k];
          lbl.still_undecided = iset[k];
          lbl.last            = (k + 1 == active_n);
          pending_labels.push_back(lbl);
        end
        computes_seen++;
      end
    endfunction

    function void check_label(out_item_t got);
      out_item_t want;
      if (pending_labels.size() == 0) begin
        $display("%0t: result item for node %0d with none pending", $time,
                 got.result_node);
        mismatches++;
        return;
      end
      want = pending_labels.pop_front();
      labels_seen++;
      if (got.result_node !== want.result_node) begin
        $display("%0t: result_node expected %0d actual %0d", $time,
                 want.result_node, got.result_node);
        mismatches++;
      end
      if (got.in_extension !== want.in_extension) begin
        $display("%0t: node %0d in_extension expected %0b actual %0b", $time,
                 want.result_node, want.in_extension, got.in_extension);
        mismatches++;
      end
      if (got.still_undecided !== want.still_undecided) begin
        $display("%0t: node %0d still_undecided expected %0b actual %0b", $time,
                 want.result_node, want.still_undecided, got.still_undecided);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: node %0d last expected %0b actual %0b", $time,
                 want.result_node, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [COUNT_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          cycle_count    = 0;
  // Rows written so far; a compute must never read a row left unwritten.
  logic [MAX_NODES-1:0] rows_loaded    = '0;
  grounded_board        board;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  grounded_extension_solver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Receiver: check each accepted result, then pick next cycle's stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_label(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               board.pending_labels.size());
      $display("tb_grounded_extension_solver: done, errors");
      $finish;
    end
  end

  // Attacker row for an active count of n: mostly sparse within the active
  // nodes so the fixed point takes several rounds; sometimes empty, full, or
  // dense, and sometimes with junk above n that the block must ignore.
  function automatic logic [MAX_NODES-1:0] pick_row(int unsigned n);
    logic [MAX_NODES-1:0] r;
    int unsigned          kind;
    kind = $urandom_range(9);
    r    = '0;
    case (kind)
      0: r = '0;
      1: r = '1;
      2: r = {$urandom, $urandom};
      default: begin
        repeat ($urandom_range(1, 3)) r[$urandom_range(n - 1)] = 1'b1;
        if (n < MAX_NODES && $urandom_range(99) < 30)
          r |= {$urandom, $urandom} & ~((64'd1 << n) - 64'd1);
      end
    endcase
    return r;
  endfunction

  // Present one item, hold it until accepted, then note it. Drop valid only
  // for idle cycles so back-to-back items keep valid high.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    if (it.operation == OP_LOAD) rows_loaded[it.node] = 1'b1;
  endtask

  task automatic load_row(input int unsigned node, input logic [MAX_NODES-1:0] row,
                          input logic g, input logic c);
    in_item_t it;
    it.operation    = OP_LOAD;
    it.node         = NODE_W'(node);
    it.attackers    = row;
    it.in_graph     = g;
    it.in_candidate = c;
    send_item(it);
  endtask

  task automatic load_random(input int unsigned node);
    load_row(node, pick_row(board.active_n), $urandom_range(99) < 80,
             $urandom_range(99) < 70);
  endtask

  // Compute with random junk in the fields that a compute ignores.
  task automatic run_compute();
    in_item_t it;
    it.operation    = OP_COMPUTE;
    it.node         = NODE_W'($urandom);
    it.attackers    = {$urandom, $urandom};
    it.in_graph     = 1'($urandom_range(1));
    it.in_candidate = 1'($urandom_range(1));
    send_item(it);
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_labels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_count(v);
  endtask

  // Short directed set at five nodes: attack chain, self-attack, rows whose
  // only attackers are inactive, candidates outside G, empty sets, mutual attack.
  task automatic directed_checks();
    write_count(COUNT_W'(5));
    load_row(0, '0, 1'b1, 1'b1);
    load_row(1, 64'h1, 1'b1, 1'b1);
    load_row(2, 64'h2, 1'b1, 1'b1);
    load_row(3, 64'h4, 1'b1, 1'b1);
    load_row(4, '1, 1'b1, 1'b1);
    run_compute();
    // Inactive node: its flags and row must not matter.
    load_row(MAX_NODES - 1, '1, 1'b1, 1'b1);
    // Attacked only by inactive nodes and not a candidate: stays undecided.
    load_row(2, 64'hFFFF_FFFF_FFFF_FFE0, 1'b1, 1'b0);
    run_compute();
    // Candidate outside G joins E; the G node it attacks leaves I.
    load_row(0, '0, 1'b0, 1'b1);
    load_row(1, 64'h1, 1'b1, 1'b0);
    run_compute();
    for (int k = 0; k < 5; k++) load_row(k, '0, 1'b0, 1'b0);
    run_compute();
    // Mutual attack between candidates: neither is accepted.
    load_row(0, 64'h2, 1'b1, 1'b1);
    load_row(1, 64'h1, 1'b1, 1'b1);
    load_row(2, '0, 1'b1, 1'b1);
    run_compute();
  endtask

  // One phase: reconfigure while idle, fill in unwritten active rows, then
  // mostly load bursts closed by a compute, with stray loads and computes.
  task automatic run_phase(input logic [COUNT_W-1:0] count, input int unsigned mode,
                           input int unsigned quota);
    int unsigned sent;
    int unsigned burst;
    int unsigned n;
    wait_drained();
    write_count(count);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
    n = board.active_n;
    for (int k = 0; k < n; k++)
      if (!rows_loaded[k]) load_random(k);
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 80) begin
        burst = $urandom_range(1, (n < 6) ? n : 6);
        repeat (burst) load_random($urandom_range(n - 1));
        run_compute();
        sent += burst + 1;
      end else if ($urandom_range(1)) begin
        load_random($urandom_range(MAX_NODES - 1));
        sent++;
      end else begin
        run_compute();
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();

    run_phase(COUNT_W'(8), 0, 30);
    run_phase(COUNT_W'(64), 1, 40);
    run_phase(COUNT_W'(1), 2, 20);
    run_phase(COUNT_W'(0), 3, 20);
    run_phase(COUNT_W'(127), 0, 30);
    run_phase(COUNT_W'(16), 2, 40);
    run_phase(COUNT_W'($urandom_range(2, 63)), 1, 30);
    run_phase(COUNT_W'(3), 3, 20);
    run_phase(COUNT_W'(64), 3, 30);

    wait_drained();

    $display("covered %0d loads and %0d computes, %0d result items checked,",
             board.loads_seen, board.computes_seen, board.labels_seen);
    $display("node counts from 0 to 127 under free, idle, stalled and mixed pacing");
    if (board.mismatches == 0 && board.pending_labels.size() == 0) begin
      $display("tb_grounded_extension_solver: done, clean");
    end else begin
      $display("tb_grounded_extension_solver: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gesolv_pkg.sv
hdl/grounded_extension_solver.sv
dv/tb_grounded_extension_solver.sv
